>>> hw/rtl/sbmq_pkg.sv
// Package for the shared-buffer multi-queue: default sizes, payload structs,
// operation and status codes, and the sequencer state type.
// No dependencies; used by the top level and the RAM wrapper users.
package sbmq_pkg;

    localparam int SBMQ_ENTRIES    = 64;
    localparam int SBMQ_QUEUES     = 8;
    localparam int SBMQ_DATA_WIDTH = 32;

    localparam int QID_WIDTH   = 3;
    localparam int FIELD_WIDTH = 32;

    typedef enum logic
    {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        kind_t                          kind;
        logic [QID_WIDTH-1:0]           queue_id;
        logic signed [FIELD_WIDTH-1:0]  value;
    } req_t;

    typedef struct packed
    {
        status_t                        status;
        logic signed [FIELD_WIDTH-1:0]  data;
    } rsp_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_READ,
        S_LINK,
        S_POP
    } seq_state_t;

endpackage

>>> hw/rtl/sbmq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; instanced for the data, link and queue-pointer stores.
module sbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/shared_buffer_multi_queue.sv
// Top level of the shared-buffer multi-queue: sequencer, free-list and queue
// pointer bookkeeping around three sbmq_ram instances.
// Depends on sbmq_pkg and sbmq_ram.
//
//   Channel  Signals                  Direction  Carries
//   req      req_valid/req_ready/req  in         push or pop of one queue
//   rsp      rsp_valid/rsp_ready/rsp  out        status and data, one per req
//
// Operations: a push or a refused operation is answered from S_READ and a successful pop
// from S_POP, as the head entry's link is read before the queue head moves.
// A push onto a non-empty queue links the old tail while the next request is taken.
// Reset: queues read empty through per-queue valid bits; a fill count stands in for
// the reset chain of the free list, so no clearing pass is needed after reset.
// Stalls: while the sink holds rsp, the next operation waits before any memory write.
module shared_buffer_multi_queue #(
    parameter int ENTRIES    = sbmq_pkg::SBMQ_ENTRIES,
    parameter int QUEUES     = sbmq_pkg::SBMQ_QUEUES,
    parameter int DATA_WIDTH = sbmq_pkg::SBMQ_DATA_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  sbmq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output sbmq_pkg::rsp_t rsp
);

    import sbmq_pkg::*;

    // A pointer is an entry index; the value ENTRIES stands for null.
    localparam int PW  = $clog2(ENTRIES + 1);
    localparam int EAW = $clog2(ENTRIES);
    localparam int QAW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(ENTRIES);

    // Control state.
    seq_state_t         state_reg, state_next;
    logic [PW-1:0]      free_head_reg, free_head_next;
    logic [PW-1:0]      fill_reg, fill_next;
    logic [QUEUES-1:0]  qvalid_reg, qvalid_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Operation being worked on.
    kind_t                 kind_reg, kind_next;
    logic [QID_WIDTH-1:0]  q_reg, q_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [PW-1:0]         slot_reg, slot_next;
    logic [PW-1:0]         tail_reg, tail_next;
    rsp_t                  rsp_reg, rsp_next;

    // Memory ports.
    logic                  dram_wr_en, dram_rd_en;
    logic [EAW-1:0]        dram_wr_addr, dram_rd_addr;
    logic [DATA_WIDTH-1:0] dram_wr_data, dram_rd_data;
    logic                  lram_wr_en, lram_rd_en;
    logic [EAW-1:0]        lram_wr_addr, lram_rd_addr;
    logic [PW-1:0]         lram_wr_data, lram_rd_data;
    logic                  qram_wr_en, qram_rd_en;
    logic [QAW-1:0]        qram_wr_addr, qram_rd_addr;
    logic [2*PW-1:0]       qram_wr_data, qram_rd_data;

    // Decode of the queue pointers read for the current operation.
    logic           accept;
    logic           out_free;
    logic [QAW-1:0] qaddr;
    logic           q_ok;
    logic           qv;
    logic [PW-1:0]  head_cur, tail_cur;
    logic           head_valid, tail_valid, free_valid;
    logic           push_ok, pop_ok;
    logic           slot_fresh;

    sbmq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_data_ram (
        .clk     (clk),
        .wr_en   (dram_wr_en),
        .wr_addr (dram_wr_addr),
        .wr_data (dram_wr_data),
        .rd_en   (dram_rd_en),
        .rd_addr (dram_rd_addr),
        .rd_data (dram_rd_data)
    );

    sbmq_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_link_ram (
        .clk     (clk),
        .wr_en   (lram_wr_en),
        .wr_addr (lram_wr_addr),
        .wr_data (lram_wr_data),
        .rd_en   (lram_rd_en),
        .rd_addr (lram_rd_addr),
        .rd_data (lram_rd_data)
    );

    // Each word holds a queue's head pointer above its tail pointer.
    sbmq_ram #(.WIDTH(2 * PW), .DEPTH(QUEUES)) u_queue_ram (
        .clk     (clk),
        .wr_en   (qram_wr_en),
        .wr_addr (qram_wr_addr),
        .wr_data (qram_wr_data),
        .rd_en   (qram_rd_en),
        .rd_addr (qram_rd_addr),
        .rd_data (qram_rd_data)
    );

    assign req_ready = (state_reg == S_IDLE) || (state_reg == S_LINK);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A queue that has never been written reads as empty.
    assign qaddr      = QAW'(q_reg);
    assign q_ok       = int'(q_reg) < QUEUES;
    assign qv         = q_ok && qvalid_reg[qaddr];
    assign head_cur   = qv ? qram_rd_data[2*PW-1:PW] : NULL_PTR;
    assign tail_cur   = qv ? qram_rd_data[PW-1:0] : NULL_PTR;
    assign head_valid = head_cur < NULL_PTR;
    assign tail_valid = tail_cur < NULL_PTR;
    assign free_valid = free_head_reg < NULL_PTR;
    assign push_ok    = q_ok && free_valid;
    assign pop_ok     = q_ok && head_valid;

    // Entries at or above the fill count have never been allocated, so their
    // link word is unwritten and the next entry in index order stands in for it.
    assign slot_fresh = free_head_reg >= fill_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (kind_reg == KIND_POP && pop_ok)
                begin
                    state_next = S_POP;
                end
                else if (out_free)
                begin
                    if (kind_reg == KIND_PUSH && push_ok && head_valid && tail_valid)
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LINK:
            begin
                state_next = req_valid ? S_READ : S_IDLE;
            end
            S_POP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory controls and register updates.
    always_comb
    begin
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        qvalid_next    = qvalid_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        kind_next      = kind_reg;
        q_next         = q_reg;
        val_next       = val_reg;
        slot_next      = slot_reg;
        tail_next      = tail_reg;
        rsp_next       = rsp_reg;

        dram_wr_en   = 1'b0;
        dram_wr_addr = slot_reg[EAW-1:0];
        dram_wr_data = val_reg;
        dram_rd_en   = 1'b0;
        dram_rd_addr = head_cur[EAW-1:0];
        lram_wr_en   = 1'b0;
        lram_wr_addr = slot_reg[EAW-1:0];
        lram_wr_data = NULL_PTR;
        lram_rd_en   = 1'b0;
        lram_rd_addr = free_head_reg[EAW-1:0];
        qram_wr_en   = 1'b0;
        qram_wr_addr = qaddr;
        qram_wr_data = {head_cur, tail_cur};
        qram_rd_en   = 1'b0;
        qram_rd_addr = QAW'(req.queue_id);

        // A new request fetches its queue's pointers and, for a push, the
        // link of the first free entry.
        if (accept)
        begin
            kind_next  = req.kind;
            q_next     = req.queue_id;
            val_next   = DATA_WIDTH'($unsigned(req.value));
            qram_rd_en = 1'b1;
            lram_rd_en = 1'b1;
        end

        case (state_reg)
            S_READ:
            begin
                if (kind_reg == KIND_PUSH)
                begin
                    if (out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        if (push_ok)
                        begin
                            // Take the first free entry and make it the new tail.
                            slot_next      = free_head_reg;
                            tail_next      = tail_cur;
                            free_head_next = slot_fresh ? free_head_reg + PW'(1)
                                                        : lram_rd_data;
                            if (slot_fresh)
                            begin
                                fill_next = free_head_reg + PW'(1);
                            end
                            dram_wr_en   = 1'b1;
                            dram_wr_addr = free_head_reg[EAW-1:0];
                            lram_wr_en   = 1'b1;
                            lram_wr_addr = free_head_reg[EAW-1:0];
                            lram_wr_data = NULL_PTR;
                            qram_wr_en   = 1'b1;
                            qram_wr_data = {(head_valid ? head_cur : free_head_reg),
                                            free_head_reg};
                            qvalid_next[qaddr] = 1'b1;
                            rsp_next.status    = ST_OK;
                            rsp_next.data      = FIELD_WIDTH'(val_reg);
                        end
                        else
                        begin
                            rsp_next.status = ST_FULL;
                            rsp_next.data   = '0;
                        end
                    end
                end
                else
                begin
                    if (pop_ok)
                    begin
                        // Fetch the head entry's link and data.
                        slot_next    = head_cur;
                        tail_next    = tail_cur;
                        lram_rd_en   = 1'b1;
                        lram_rd_addr = head_cur[EAW-1:0];
                        dram_rd_en   = 1'b1;
                        dram_rd_addr = head_cur[EAW-1:0];
                    end
                    else if (out_free)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_next.status = ST_EMPTY;
                        rsp_next.data   = '0;
                    end
                end
            end
            S_LINK:
            begin
                // Chain the old tail to the entry just appended.
                lram_wr_en   = 1'b1;
                lram_wr_addr = tail_reg[EAW-1:0];
                lram_wr_data = slot_reg;
            end
            S_POP:
            begin
                if (out_free)
                begin
                    // Unlink the head and return its entry to the free list front.
                    qram_wr_en      = 1'b1;
                    qram_wr_data    = {lram_rd_data, tail_reg};
                    lram_wr_en      = 1'b1;
                    lram_wr_addr    = slot_reg[EAW-1:0];
                    lram_wr_data    = free_head_reg;
                    free_head_next  = slot_reg;
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = ST_OK;
                    rsp_next.data   = FIELD_WIDTH'(dram_rd_data);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            fill_reg      <= '0;
            qvalid_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            qvalid_reg    <= qvalid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        q_reg    <= q_next;
        val_reg  <= val_next;
        slot_reg <= slot_next;
        tail_reg <= tail_next;
        rsp_reg  <= rsp_next;
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for shared_buffer_multi_queue: directed and random pushes and
// pops, with results compared against a behavioural model of the queues. Needs sbmq_pkg.
module tb_top;

    import sbmq_pkg::*;

    // The block is used with the package's default sizes. The pointer width leaves room
    // for the null value, which is one past the last entry.
    localparam int ENTRIES    = SBMQ_ENTRIES;
    localparam int QUEUES     = SBMQ_QUEUES;
    localparam int DATA_WIDTH = SBMQ_DATA_WIDTH;
    localparam int PTR_WIDTH  = $clog2(ENTRIES + 1);
    localparam logic [PTR_WIDTH-1:0] NULL_PTR = PTR_WIDTH'(ENTRIES);

    // The slowest correct run is roughly 1500 transfers, when both sides stall heavily.
    // The limit sits far above what such a run needs.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Idle rates, in percent, for the request side and the response side.
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    int fail_count  = 0;
    int cycle_count = 0;

    // Results that have been predicted but not yet seen, oldest first.
    rsp_t pending_rsp_q[$];

    // Shadow copy of the shared store: the data words, the link of each entry, the head
    // and tail of every queue and the head of the free list.
    logic [DATA_WIDTH-1:0] entry_word[ENTRIES];
    logic [PTR_WIDTH-1:0]  next_link[ENTRIES];
    logic [PTR_WIDTH-1:0]  q_head[QUEUES];
    logic [PTR_WIDTH-1:0]  q_tail[QUEUES];
    logic [PTR_WIDTH-1:0]  free_head;

    shared_buffer_multi_queue dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // A run that hangs is ended here rather than left to spin.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rsp_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // After reset the free list chains every entry in index order and no queue holds
    // anything. Data words start at zero, although a pop never reaches one unwritten.
    function automatic void reset_queue_model();
        for (int i = 0; i < ENTRIES; i++)
        begin
            entry_word[i] = '0;
            next_link[i]  = (i == ENTRIES - 1) ? NULL_PTR : PTR_WIDTH'(i + 1);
        end
        for (int q = 0; q < QUEUES; q++)
        begin
            q_head[q] = NULL_PTR;
            q_tail[q] = NULL_PTR;
        end
        free_head = '0;
    endfunction

    // Applies one operation to the shadow store and returns the result it gives. Any
    // pointer at or beyond the null value counts as null, as in the block.
    function automatic rsp_t apply_queue_op(input req_t op);
        rsp_t                  res;
        int unsigned           q;
        logic [PTR_WIDTH-1:0]  slot;
        logic [DATA_WIDTH-1:0] word;
        q          = op.queue_id;
        res.status = ST_OK;
        res.data   = '0;
        if (op.kind == KIND_PUSH)
        begin
            if (q >= QUEUES || free_head >= NULL_PTR)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                // Take the first free entry and hang it on the end of the queue. A queue
                // that was emptied keeps a stale tail, which is simply overwritten here.
                word      = op.value[DATA_WIDTH-1:0];
                slot      = free_head;
                free_head = next_link[slot];
                if (q_head[q] >= NULL_PTR)
                    q_head[q] = slot;
                else if (q_tail[q] < NULL_PTR)
                    next_link[q_tail[q]] = slot;
                next_link[slot]  = NULL_PTR;
                q_tail[q]        = slot;
                entry_word[slot] = word;
                res.data         = FIELD_WIDTH'(word);
            end
        end
        else
        begin
            if (q >= QUEUES || q_head[q] >= NULL_PTR)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                // Unlink the head entry and return it to the front of the free list.
                slot            = q_head[q];
                q_head[q]       = next_link[slot];
                next_link[slot] = free_head;
                free_head       = slot;
                res.data        = FIELD_WIDTH'(entry_word[slot]);
            end
        end
        return res;
    endfunction

    // Only the first few failures are described in full; the rest are just counted.
    function automatic void log_failure(input string what, input rsp_t want, input rsp_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s: expected status %0d data %h, got status %0d data %h",
                     $time, what, want.status, want.data, got.status, got.data);
    endfunction

    // Response side: every result transfer is checked against the oldest prediction, and
    // ready is redrawn at each edge so that stalls fall on every phase of an operation.
    always @(posedge clk)
    begin : rsp_monitor
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                want = '0;
                log_failure("Result with nothing pending", want, rsp);
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp.status !== want.status || rsp.data !== want.data)
                    log_failure("Result mismatch", want, rsp);
            end
        end
        rsp_ready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Sends one request. Valid may drop while the sender idles first; once raised it stays
    // up until the transfer happens, and it is left high so that a following request can
    // go straight out on the next edge. The prediction is made at the transfer itself.
    task automatic send_op(input req_t op);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= op;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rsp_q.push_back(apply_queue_op(op));
    endtask

    task automatic push_to(input int q, input logic [FIELD_WIDTH-1:0] word);
        req_t op;
        op.kind     = KIND_PUSH;
        op.queue_id = QID_WIDTH'(q);
        op.value    = word;
        send_op(op);
    endtask

    // The value field is ignored on a pop, so it carries noise.
    task automatic pop_from(input int q);
        req_t op;
        op.kind     = KIND_POP;
        op.queue_id = QID_WIDTH'(q);
        op.value    = $urandom;
        send_op(op);
    endtask

    // Most words are uniform; a few are the extremes of the signed range, all ones or zero.
    function automatic logic [FIELD_WIDTH-1:0] random_word();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Extreme values through the first and last queues, interleaved, must come back in
    // the order they went in, each queue on its own.
    task automatic test_fifo_order_extremes();
        push_to(0, 32'h8000_0000);
        push_to(QUEUES - 1, 32'h0000_0000);
        push_to(0, 32'h7FFF_FFFF);
        push_to(QUEUES - 1, 32'hFFFF_FFFF);
        push_to(0, 32'h5555_5555);
        push_to(QUEUES - 1, 32'hAAAA_AAAA);
        pop_from(0);
        pop_from(QUEUES - 1);
        pop_from(0);
        pop_from(0);
        pop_from(QUEUES - 1);
        pop_from(QUEUES - 1);
    endtask

    // Pops from a queue that was drained and from one that was never used are refused.
    task automatic test_pop_empty();
        pop_from(0);
        pop_from(5);
    endtask

    // Emptying a queue leaves its tail pointer stale; the next push must start the queue
    // afresh from the head rather than link onto the old tail.
    task automatic test_refill_after_empty();
        push_to(3, 32'h1234_5678);
        pop_from(3);
        push_to(3, 32'hDEAD_BEEF);
        push_to(3, 32'h0BAD_F00D);
        pop_from(3);
        pop_from(3);
        pop_from(3);
    endtask

    // Random traffic in bursts. Each burst leans towards pushes, pops or neither, and
    // at least half of its operations go to one favoured queue, so long chains build up in a
    // single queue, the store fills until pushes are refused, and queues drain to empty.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_ops);
        req_t op;
        int   burst_left;
        int   push_pct;
        int   hot_q;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        burst_left        = 0;
        push_pct          = 50;
        hot_q             = 0;
        for (int i = 0; i < n_ops; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(150, 40);
                hot_q      = $urandom_range(QUEUES - 1);
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            burst_left--;
            op.kind     = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
            op.queue_id = $urandom_range(1) ? QID_WIDTH'(hot_q)
                                            : QID_WIDTH'($urandom_range(QUEUES - 1));
            op.value    = random_word();
            send_op(op);
        end
    endtask

    initial
    begin
        reset_queue_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles a little, receiver a lot.
        sender_idle_pct   = 13;
        receiver_idle_pct = 68;
        test_fifo_order_extremes();
        test_pop_empty();
        test_refill_after_empty();
        test_random_traffic(13, 68, 500);

        // The other way round, then with no idling at all.
        test_random_traffic(68, 13, 500);
        test_random_traffic(0, 0, 500);

        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
